>>> rtl/mbq_pkg.sv
// Shared types, constants and helpers for the message block queue.
package mbq_pkg;

	localparam int unsigned SLOTS       = 32;
	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned STORE_DEPTH = SLOTS * BLOCK_BYTES;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned IDX_W       = $clog2(SLOTS);
	localparam int unsigned N_W         = $clog2(SLOTS + 1);
	localparam int unsigned G_W         = $clog2(SLOTS + 2);
	localparam int unsigned CNT_W       = 16;
	localparam int unsigned BUD_W       = 18;

	localparam logic [1:0] K_WRITE = 2'd0;
	localparam logic [1:0] K_START = 2'd1;
	localparam logic [1:0] K_FETCH = 2'd2;
	localparam logic [1:0] K_SPARE = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOBLOCK = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_TRUNC   = 3'd4;
	localparam logic [2:0] ST_NOREAD  = 3'd5;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_WRITE, S_RSTART, S_WALK, S_LEN2, S_LEN3, S_LENX,
		S_FIN, S_RETIRE, S_FSTART, S_FLOOP, S_FBODY, S_FDATA
	} state_t;

	typedef enum logic [1:0] {W_IDLE, W_ACTIVE, W_DISCARD} wmode_t;

	typedef enum logic {CTX_WALK, CTX_FETCH} ctx_t;

	typedef struct packed {
		logic take;
		logic give;
		idx_t give_blk;
		logic push;
		idx_t push_blk;
		logic retire;
	} ring_cmd_t;

	typedef struct packed {
		idx_t head_blk;
		logic free_ok;
		logic full;
		idx_t rd_idx;
		idx_t wr_idx;
		logic rd_valid;
		idx_t rd_blk;
		logic walk_valid;
		idx_t walk_blk;
	} ring_sts_t;

	function automatic idx_t next_idx(idx_t i);
		return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(idx_t blk, logic [CNT_W-1:0] off);
		return ADDR_W'(blk) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(off);
	endfunction

	function automatic logic [CNT_W-1:0] clamp_len(logic [7:0] lo, logic [7:0] hi);
		logic [CNT_W-1:0] v;
		v = {hi, lo};
		return (v > CNT_W'(BLOCK_BYTES)) ? CNT_W'(BLOCK_BYTES) : v;
	endfunction

endpackage

>>> rtl/mbq_ram.sv
// Generic single-port RAM with registered read.
module mbq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end
endmodule

>>> rtl/mbq_rings.sv
// Free-block ring, message ring and their indexes.
module mbq_rings (
	input  logic              clk,
	input  logic              arst_n,
	input  mbq_pkg::ring_cmd_t cmd,
	input  mbq_pkg::idx_t     walk_idx,
	output mbq_pkg::ring_sts_t sts
);
	import mbq_pkg::*;

	idx_t free_q [SLOTS];
	idx_t blk_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	idx_t rd_q, wr_q, head_q, tail_q;
	logic give_any;
	idx_t gblk;

	assign give_any = cmd.give || (cmd.retire && valid_q[rd_q]);
	assign gblk     = cmd.retire ? blk_q[rd_q] : cmd.give_blk;

	assign sts.head_blk   = free_q[head_q];
	assign sts.free_ok    = next_idx(head_q) != tail_q;
	assign sts.full       = next_idx(wr_q) == rd_q;
	assign sts.rd_idx     = rd_q;
	assign sts.wr_idx     = wr_q;
	assign sts.rd_valid   = valid_q[rd_q];
	assign sts.rd_blk     = blk_q[rd_q];
	assign sts.walk_valid = valid_q[walk_idx];
	assign sts.walk_blk   = blk_q[walk_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				free_q[i] <= IDX_W'(i);
				blk_q[i]  <= '0;
			end
			valid_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			head_q  <= '0;
			tail_q  <= IDX_W'(SLOTS - 1);
		end else begin
			if (cmd.take) begin
				head_q <= next_idx(head_q);
			end
			if (give_any) begin
				free_q[tail_q] <= gblk;
				tail_q         <= next_idx(tail_q);
			end
			if (cmd.push) begin
				valid_q[wr_q] <= 1'b1;
				blk_q[wr_q]   <= cmd.push_blk;
				wr_q          <= next_idx(wr_q);
			end
			if (cmd.retire) begin
				valid_q[rd_q] <= 1'b0;
				rd_q          <= next_idx(rd_q);
			end
		end
	end
endmodule

>>> rtl/message_block_queue_top.sv
// Message block queue: sequencer, writer and reader state around the block store.
//
//  beat      | qualifier          | fields
//  ----------+--------------------+-------------------------------------------------
//  command   | start & !busy      | kind, data_byte, end_of_message, byte_budget
//  result    | done (one cycle)   | status, byte_count, out_byte, last_of_read
//
// After reset the block store is zeroed, one byte a cycle, and busy stays high
// until the clear is done. A fetch first releases messages it has drained; a read
// start walks the queued messages; ending a read releases the messages it covered.
// The block store has a single port. Results cannot be stalled.
module message_block_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	input  logic [15:0] byte_budget,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] byte_count,
	output logic [7:0]  out_byte,
	output logic        last_of_read
);
	import mbq_pkg::*;

	state_t state_q, state_d;
	wmode_t wmode_q, wmode_d;
	ctx_t ctx_q, ctx_d;
	logic [7:0] byte_q;
	logic eom_q;
	logic signed [BUD_W-1:0] budget_q, budget_d;
	idx_t wblk_q, wblk_d;
	logic [CNT_W-1:0] wcnt_q, wcnt_d;
	logic wovf_q, wovf_d;
	logic pend_q, pend_d;
	logic [CNT_W-1:0] left_q, left_d, off_q, off_d, total_q, total_d, len_q, len_d;
	logic [N_W-1:0] msgs_q, msgs_d, n_q, n_d;
	logic [G_W-1:0] guard_q, guard_d;
	idx_t r_q, r_d;
	logic [7:0] lo_q, lo_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic emit;
	logic [2:0] status_d;
	logic [15:0] count_d;
	logic [7:0] obyte_d;
	logic last_d;

	logic ram_en, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata;
	ring_cmd_t cmd;
	ring_sts_t sts;

	wmode_t mode_eff;
	idx_t blk_eff, lblk;
	logic [CNT_W-1:0] cnt_eff, cnt_n, len_cur, off1, left1;
	logic ovf_eff, taking;
	logic [CNT_W:0] sum;
	idx_t r_next;

	mbq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk(clk), .en(ram_en), .we(ram_we), .addr(ram_addr),
		.wdata(ram_wdata), .rdata(ram_rdata)
	);

	mbq_rings u_rings (.clk(clk), .arst_n(arst_n), .cmd(cmd), .walk_idx(r_q), .sts(sts));

	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d  = state_q;
		wmode_d  = wmode_q;
		ctx_d    = ctx_q;
		budget_d = budget_q;
		wblk_d   = wblk_q;
		wcnt_d   = wcnt_q;
		wovf_d   = wovf_q;
		pend_d   = pend_q;
		left_d   = left_q;
		off_d    = off_q;
		total_d  = total_q;
		len_d    = len_q;
		msgs_d   = msgs_q;
		n_d      = n_q;
		guard_d  = guard_q;
		r_d      = r_q;
		lo_d     = lo_q;
		clr_d    = clr_q;
		emit     = 1'b0;
		status_d = status;
		count_d  = byte_count;
		obyte_d  = out_byte;
		last_d   = last_of_read;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = '0;
		ram_wdata = byte_q;
		cmd      = '0;

		taking   = (wmode_q == W_IDLE) && sts.free_ok;
		mode_eff = (wmode_q == W_IDLE) ? (sts.free_ok ? W_ACTIVE : W_DISCARD) : wmode_q;
		blk_eff  = taking ? sts.head_blk : wblk_q;
		cnt_eff  = taking ? '0 : wcnt_q;
		ovf_eff  = taking ? 1'b0 : wovf_q;
		cnt_n    = cnt_eff;
		lblk     = (ctx_q == CTX_WALK) ? sts.walk_blk : sts.rd_blk;
		len_cur  = clamp_len(lo_q, ram_rdata);
		sum      = {1'b0, total_q} + {1'b0, len_cur};
		r_next   = next_idx(r_q);
		off1     = off_q + 1'b1;
		left1    = left_q - 1'b1;

		unique case (state_q)
			S_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					budget_d = BUD_W'(byte_budget);
					unique case (kind)
						K_WRITE: state_d = S_WRITE;
						K_START: state_d = S_RSTART;
						K_FETCH: state_d = S_FSTART;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WRITE: begin
				cmd.take = taking;
				wovf_d   = ovf_eff;
				if (mode_eff == W_ACTIVE) begin
					if (cnt_eff < CNT_W'(BLOCK_BYTES)) begin
						ram_en   = 1'b1;
						ram_we   = 1'b1;
						ram_addr = store_addr(blk_eff, cnt_eff);
						cnt_n    = cnt_eff + 1'b1;
					end else begin
						wovf_d = 1'b1;
					end
				end
				wblk_d  = blk_eff;
				wcnt_d  = cnt_n;
				wmode_d = mode_eff;
				state_d = S_IDLE;
				if (eom_q) begin
					wmode_d  = W_IDLE;
					emit     = 1'b1;
					obyte_d  = '0;
					last_d   = 1'b0;
					count_d  = '0;
					if (mode_eff == W_DISCARD) begin
						status_d = ST_NOBLOCK;
					end else if (sts.full) begin
						cmd.give     = 1'b1;
						cmd.give_blk = blk_eff;
						status_d     = ST_FULL;
					end else begin
						cmd.push     = 1'b1;
						cmd.push_blk = blk_eff;
						status_d     = wovf_d ? ST_TRUNC : ST_OK;
						count_d      = cnt_n;
					end
				end
			end
			S_RSTART: begin
				obyte_d = '0;
				last_d  = 1'b0;
				if (pend_q) begin
					emit     = 1'b1;
					status_d = ST_OK;
					count_d  = left_q;
					state_d  = S_IDLE;
				end else if (sts.rd_idx == sts.wr_idx || !sts.rd_valid) begin
					emit     = 1'b1;
					status_d = ST_EMPTY;
					count_d  = '0;
					state_d  = S_IDLE;
				end else begin
					r_d     = sts.rd_idx;
					n_d     = '0;
					total_d = '0;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (budget_q > 0 && n_q < N_W'(SLOTS) && sts.walk_valid) begin
					ctx_d   = CTX_WALK;
					state_d = S_LEN2;
				end else begin
					state_d = S_FIN;
				end
			end
			S_LEN2: begin
				ram_en   = 1'b1;
				ram_addr = store_addr(lblk, CNT_W'(2));
				state_d  = S_LEN3;
			end
			S_LEN3: begin
				ram_en   = 1'b1;
				ram_addr = store_addr(lblk, CNT_W'(3));
				lo_d     = ram_rdata;
				state_d  = S_LENX;
			end
			S_LENX: begin
				if (ctx_q == CTX_WALK) begin
					if (sum[CNT_W]) begin
						state_d = S_FIN;
					end else begin
						budget_d = budget_q - $signed({2'b00, len_cur});
						total_d  = sum[CNT_W-1:0];
						n_d      = n_q + 1'b1;
						r_d      = r_next;
						state_d  = (r_next == sts.wr_idx) ? S_FIN : S_WALK;
					end
				end else begin
					len_d = len_cur;
					if (off_q >= len_cur) begin
						cmd.retire = 1'b1;
						if (msgs_q != '0) begin
							msgs_d = msgs_q - 1'b1;
						end
						off_d   = '0;
						guard_d = guard_q + 1'b1;
						state_d = S_FLOOP;
					end else begin
						state_d = S_FBODY;
					end
				end
			end
			S_FIN: begin
				msgs_d   = n_q;
				off_d    = '0;
				left_d   = total_q;
				status_d = ST_OK;
				count_d  = total_q;
				if (total_q == '0) begin
					pend_d  = 1'b0;
					state_d = S_RETIRE;
				end else begin
					pend_d  = 1'b1;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RETIRE: begin
				if (msgs_q != '0) begin
					cmd.retire = 1'b1;
					msgs_d     = msgs_q - 1'b1;
				end else begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FSTART: begin
				if (!pend_q) begin
					emit     = 1'b1;
					status_d = ST_NOREAD;
					count_d  = '0;
					obyte_d  = '0;
					last_d   = 1'b0;
					state_d  = S_IDLE;
				end else begin
					guard_d = '0;
					state_d = S_FLOOP;
				end
			end
			S_FLOOP: begin
				if (msgs_q != '0 && guard_q <= G_W'(SLOTS)) begin
					ctx_d   = CTX_FETCH;
					state_d = S_LEN2;
				end else begin
					state_d = S_FBODY;
				end
			end
			S_FBODY: begin
				if (msgs_q == '0 || left_q == '0) begin
					pend_d   = 1'b0;
					left_d   = '0;
					off_d    = '0;
					status_d = ST_NOREAD;
					count_d  = '0;
					obyte_d  = '0;
					last_d   = 1'b0;
					state_d  = S_RETIRE;
				end else begin
					ram_en   = 1'b1;
					ram_addr = store_addr(sts.rd_blk, off_q);
					state_d  = S_FDATA;
				end
			end
			S_FDATA: begin
				obyte_d  = ram_rdata;
				status_d = ST_OK;
				left_d   = left1;
				if (left1 == '0) begin
					pend_d  = 1'b0;
					off_d   = '0;
					count_d = '0;
					last_d  = 1'b1;
					state_d = S_RETIRE;
				end else begin
					if (off1 >= len_q) begin
						cmd.retire = 1'b1;
						if (msgs_q != '0) begin
							msgs_d = msgs_q - 1'b1;
						end
						off_d = '0;
					end else begin
						off_d = off1;
					end
					count_d = left1;
					last_d  = 1'b0;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			wmode_q <= W_IDLE;
			pend_q  <= 1'b0;
			left_q  <= '0;
			off_q   <= '0;
			msgs_q  <= '0;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			wmode_q <= wmode_d;
			pend_q  <= pend_d;
			left_q  <= left_d;
			off_q   <= off_d;
			msgs_q  <= msgs_d;
			clr_q   <= clr_d;
			done    <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			byte_q <= data_byte;
			eom_q  <= end_of_message;
		end
		ctx_q        <= ctx_d;
		budget_q     <= budget_d;
		wblk_q       <= wblk_d;
		wcnt_q       <= wcnt_d;
		wovf_q       <= wovf_d;
		total_q      <= total_d;
		len_q        <= len_d;
		n_q          <= n_d;
		guard_q      <= guard_d;
		r_q          <= r_d;
		lo_q         <= lo_d;
		status       <= status_d;
		byte_count   <= count_d;
		out_byte     <= obyte_d;
		last_of_read <= last_d;
	end
endmodule

>>> test/message_block_queue_checker.sv
// Checker for the message block queue: predicts each result and compares it with the block's.
module message_block_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	input  logic [15:0] byte_budget,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [15:0] byte_count,
	input  logic [7:0]  out_byte,
	input  logic        last_of_read,
	output int          fails,
	output int          outstanding,
	output logic        read_open
);
	import mbq_pkg::*;

	typedef struct packed {
		logic [2:0]  st;
		logic [15:0] cnt;
		logic [7:0]  ob;
		logic        last;
	} beat_t;

	beat_t  exp_beats[$];
	logic [7:0] store [STORE_DEPTH];
	idx_t   free_ring [SLOTS];
	logic   slot_valid [SLOTS];
	idx_t   slot_blk [SLOTS];
	idx_t   rd_idx, wr_idx, pool_rd, pool_wr;
	wmode_t wmode;
	idx_t   wblk;
	int     wcount;
	bit     wover;
	bit     dpend;
	int     dmsgs, doff, dleft;

	assign outstanding = exp_beats.size();
	assign read_open   = dpend;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	function automatic int msg_len(input idx_t b);
		int v;
		v = {store[int'(b) * BLOCK_BYTES + 3], store[int'(b) * BLOCK_BYTES + 2]};
		return (v > BLOCK_BYTES) ? BLOCK_BYTES : v;
	endfunction

	function automatic void give_block(input idx_t b);
		free_ring[pool_wr] = b;
		pool_wr = idx_t'(pool_wr + 1);
	endfunction

	function automatic void retire_head();
		if (slot_valid[rd_idx]) give_block(slot_blk[rd_idx]);
		slot_valid[rd_idx] = 1'b0;
		rd_idx = idx_t'(rd_idx + 1);
		if (dmsgs > 0) dmsgs--;
	endfunction

	function automatic void push(input logic [2:0] st, input int cnt, input int ob, input bit last);
		beat_t e;
		e.st = st;
		e.cnt = cnt[15:0];
		e.ob = ob[7:0];
		e.last = last;
		exp_beats.push_back(e);
	endfunction

	function automatic void predict_write(input logic [7:0] b, input logic eom);
		if (wmode == W_IDLE) begin
			if (idx_t'(pool_rd + 1) != pool_wr) begin
				wblk = free_ring[pool_rd];
				pool_rd = idx_t'(pool_rd + 1);
				wmode = W_ACTIVE;
				wcount = 0;
				wover = 0;
			end else begin
				wmode = W_DISCARD;
			end
		end
		if (wmode == W_ACTIVE) begin
			if (wcount < BLOCK_BYTES) begin
				store[int'(wblk) * BLOCK_BYTES + wcount] = b;
				wcount++;
			end else begin
				wover = 1;
			end
		end
		if (!eom) return;
		if (wmode == W_DISCARD) begin
			wmode = W_IDLE;
			push(ST_NOBLOCK, 0, 0, 0);
			return;
		end
		wmode = W_IDLE;
		if (idx_t'(wr_idx + 1) == rd_idx) begin
			give_block(wblk);
			push(ST_FULL, 0, 0, 0);
			return;
		end
		slot_valid[wr_idx] = 1'b1;
		slot_blk[wr_idx] = wblk;
		wr_idx = idx_t'(wr_idx + 1);
		push(wover ? ST_TRUNC : ST_OK, wcount, 0, 0);
	endfunction

	function automatic void predict_start(input logic [15:0] bud);
		int   budget, n, total, sz;
		idx_t r;
		budget = bud;
		n = 0;
		total = 0;
		r = rd_idx;
		if (dpend) begin
			push(ST_OK, dleft, 0, 0);
			return;
		end
		if (rd_idx == wr_idx || !slot_valid[rd_idx]) begin
			push(ST_EMPTY, 0, 0, 0);
			return;
		end
		while (budget > 0 && n < SLOTS) begin
			if (!slot_valid[r]) break;
			sz = msg_len(slot_blk[r]);
			if (total + sz > 65535) break;
			budget -= sz;
			total += sz;
			n++;
			r = idx_t'(r + 1);
			if (r == wr_idx) break;
		end
		dmsgs = n;
		doff = 0;
		dleft = total;
		if (total == 0) begin
			for (int i = 0; i < n; i++) retire_head();
			dpend = 0;
			dmsgs = 0;
		end else begin
			dpend = 1;
		end
		push(ST_OK, total, 0, 0);
	endfunction

	function automatic void predict_fetch();
		int   guard, b;
		idx_t blk;
		guard = 0;
		if (!dpend) begin
			push(ST_NOREAD, 0, 0, 0);
			return;
		end
		while (dmsgs > 0 && guard <= SLOTS && doff >= msg_len(slot_blk[rd_idx])) begin
			retire_head();
			doff = 0;
			guard++;
		end
		if (dmsgs == 0 || dleft == 0) begin
			while (dmsgs > 0) retire_head();
			dpend = 0;
			dleft = 0;
			doff = 0;
			push(ST_NOREAD, 0, 0, 0);
			return;
		end
		blk = slot_blk[rd_idx];
		b = store[int'(blk) * BLOCK_BYTES + doff];
		doff++;
		dleft--;
		if (dleft == 0) begin
			while (dmsgs > 0) retire_head();
			dpend = 0;
			doff = 0;
			push(ST_OK, 0, b, 1);
			return;
		end
		if (doff >= msg_len(blk)) begin
			retire_head();
			doff = 0;
		end
		push(ST_OK, dleft, b, 0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) store[i] = 8'd0;
			for (int i = 0; i < SLOTS; i++) begin
				free_ring[i] = idx_t'(i);
				slot_valid[i] = 1'b0;
				slot_blk[i] = '0;
			end
			rd_idx = '0;
			wr_idx = '0;
			pool_rd = '0;
			pool_wr = idx_t'(SLOTS - 1);
			wmode = W_IDLE;
			wblk = '0;
			wcount = 0;
			wover = 0;
			dpend = 0;
			dmsgs = 0;
			doff = 0;
			dleft = 0;
			fails = 0;
			exp_beats.delete();
		end else begin
			if (done) begin
				if (exp_beats.size() == 0) begin
					report("unexpected result, status", status, 0);
				end else begin
					beat_t e;
					e = exp_beats.pop_front();
					if (status !== e.st) report("status", status, e.st);
					if (byte_count !== e.cnt) report("byte_count", byte_count, e.cnt);
					if (out_byte !== e.ob) report("out_byte", out_byte, e.ob);
					if (last_of_read !== e.last) report("last_of_read", last_of_read, e.last);
				end
			end
			if (start && !busy) begin
				case (kind)
					K_WRITE: predict_write(data_byte, end_of_message);
					K_START: predict_start(byte_budget);
					K_FETCH: predict_fetch();
					default: ;
				endcase
			end
		end
	end

endmodule

>>> test/message_block_queue_top_test.sv
// Testbench top for the message block queue: stimulus, clock, reset and verdict.
module message_block_queue_top_test;
	import mbq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = K_WRITE;
	logic [7:0]  data_byte = 8'd0;
	logic        end_of_message = 1'b0;
	logic [15:0] byte_budget = 16'd0;
	logic        done;
	logic [2:0]  status;
	logic [15:0] byte_count;
	logic [7:0]  out_byte;
	logic        last_of_read;
	int          fails;
	int          outstanding;
	logic        read_open;
	int          sent = 0;
	int          burst = 0;

	message_block_queue_top u_dut (.*);

	message_block_queue_checker u_chk (.*);

	always #4 clk = ~clk;

	initial begin
		#30000000;
		$display("status: fail");
		$finish;
	end

	task automatic put(input logic [1:0] k, input logic [7:0] b, input logic eom,
			input logic [15:0] bud);
		kind = k;
		data_byte = b;
		end_of_message = eom;
		byte_budget = bud;
		start = 1'b1;
		while (busy) @(negedge clk);
		@(negedge clk);
		sent++;
		if (burst > 0) burst--;
		if (burst == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				start = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst = $urandom_range(1, 40);
		end
	endtask

	task automatic drain_wait();
		start = 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic send_msg(input int n, input logic [15:0] hdr);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = (i == 2) ? hdr[7:0] : (i == 3) ? hdr[15:8] : 8'($urandom);
			put(K_WRITE, b, i == n - 1, 16'($urandom));
		end
	endtask

	task automatic do_read(input logic [15:0] bud, input int cut);
		int k;
		k = 0;
		put(K_START, 8'($urandom), 1'($urandom), bud);
		while (read_open && k != cut) begin
			put(K_FETCH, 8'($urandom), 1'($urandom), 16'($urandom));
			k++;
		end
	endtask

	initial begin
		int r;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		burst = 10;

		put(K_FETCH, 8'd0, 1'b0, 16'd0);
		put(K_START, 8'hFF, 1'b1, 16'hFFFF);
		put(K_SPARE, 8'h55, 1'b1, 16'h1234);
		send_msg(1, 16'd0);
		send_msg(6, 16'd4);
		send_msg(520, 16'hFFFF);
		send_msg(4, 16'd0);
		do_read(16'd0, -1);
		do_read(16'd1, 2);
		put(K_START, 8'd0, 1'b0, 16'd5);
		do_read(16'hFFFF, -1);
		put(K_FETCH, 8'd0, 1'b0, 16'd0);
		for (int i = 0; i < 32; i++) send_msg(4, 16'(i % 3));
		drain_wait();
		do_read(16'hFFFF, -1);
		do_read(16'h8000, -1);

		while (sent < 950) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_msg($urandom_range(1, 12),
					($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 14)));
			else if (r < 46)
				send_msg($urandom_range(500, 530), 16'($urandom_range(500, 600)));
			else if (r < 85)
				do_read(($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30)),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : -1);
			else if (r < 89)
				put(K_FETCH, 8'($urandom), 1'($urandom), 16'($urandom));
			else if (r < 93)
				put(K_START, 8'($urandom), 1'($urandom), 16'($urandom));
			else if (r < 96)
				put(K_SPARE, 8'($urandom), 1'($urandom), 16'($urandom));
			else
				drain_wait();
		end

		drain_wait();
		repeat (200) @(negedge clk);
		if (fails == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
